/* src/bba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
	localparam int MIN_ORDER_D = 12;
	localparam int MAX_ORDER_D = 20;
	localparam int REGION_ORDER_D = 24;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_RANGE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// bitmap write target
	localparam logic [1:0] SEL_CUR = 2'd0;
	localparam logic [1:0] SEL_BUDDY = 2'd1;
	localparam logic [1:0] SEL_LEFT = 2'd2;
	localparam logic [1:0] SEL_RIGHT = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] address;
		logic [31:0] length;
	} req_t;

	typedef struct packed {
		logic [31:0] block_address;
		logic [1:0]  status;
	} rsp_t;

	// datapath commands from controller
	typedef struct packed {
		logic load;       // capture request, compute order
		logic clr_start;  // start clearing sweep
		logic scan;       // read bit at scan pointer
		logic scan_next;  // advance scan
		logic rd_buddy;   // read buddy bit
		logic put;        // write bit (wr_val, sel)
		logic [1:0] put_sel; // current, buddy, left or right child one order down
		logic wr_val;
		logic go_up;      // idx>>=1, o++
		logic go_down;    // idx<<=1, o--
		logic rng_init;
		logic set_free_blk; // load o/idx from range pick
		logic done;
	} cmd_t;

	typedef struct packed {
		logic clr_busy;
		logic order_big;  // requested order above max
		logic idx_bad;    // free index beyond region
		logic at_max;     // current order is max
		logic at_want;    // current order equals want
		logic rd_bit;     // registered read data
		logic scan_end;   // at last block of order
		logic scan_top;   // order at max
		logic rng_more;   // extent left and aligned
		logic rng_ok;     // a block was found
	} sts_t;
endpackage
`default_nettype wire

/* src/buddy_block_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// alloc scans bitmap bits from the wanted order upward, then splits the found block down
// to the wanted order; free sets its bit and merges with a free buddy order by order,
// up to the top order at most; free range carves aligned blocks and frees each in turn
// one operation at a time; busy drops with the strobe, next start is taken in that cycle
// reset leaves nothing free and clears the 8192-bit bitmap; busy while it clears
// the result is shown for one cycle and cannot be stalled
module buddy_block_allocator #(
	parameter int MIN_ORDER = bba_pkg::MIN_ORDER_D,
	parameter int MAX_ORDER = bba_pkg::MAX_ORDER_D,
	parameter int REGION_ORDER = bba_pkg::REGION_ORDER_D
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  bba_pkg::req_t     req,
	output logic              result_valid,
	output bba_pkg::rsp_t     result,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data
);
	import bba_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic [31:0] base_q, blk;
	logic [1:0] stat;
	logic ok;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_valid) base_q <= cfg_data;
	end

	bba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(req.op), .busy(busy),
		.result_valid(result_valid), .status(stat), .addr_ok(ok), .cmd(cmd), .sts(sts)
	);

	bba_datapath #(.MIN_ORDER(MIN_ORDER), .MAX_ORDER(MAX_ORDER),
		.REGION_ORDER(REGION_ORDER)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .base(base_q), .cmd(cmd),
		.sts(sts), .blk_addr(blk)
	);

	assign result = {(ok ? blk : 32'd0), stat};

`ifndef NO_ASSERTIONS
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(start && !busy)) else $error("result too early");
	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.block_address == 32'd0)
		else $error("address on failure");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("busy after result");
`endif
endmodule
`default_nettype wire

/* src/bba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/bba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module bba_datapath #(
	parameter int MIN_ORDER = 12,
	parameter int MAX_ORDER = 20,
	parameter int REGION_ORDER = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  bba_pkg::req_t      req,
	input  wire logic [31:0]   base,
	input  bba_pkg::cmd_t      cmd,
	output bba_pkg::sts_t      sts,
	output logic [31:0]        blk_addr
);
	import bba_pkg::*;
	localparam int MAP_BITS = 2 << (REGION_ORDER - MIN_ORDER);
	localparam int AW = $clog2(MAP_BITS);
	localparam int IW = REGION_ORDER - MIN_ORDER + 1;
	localparam logic [63:0] MIN_SZ = 64'd1 << MIN_ORDER;

	logic [5:0]  ord_q, want_q;
	logic [IW-1:0] idx_q;
	logic [AW:0] clr_q;
	logic [32:0] ext_q, start_q;
	logic        idx_bad_q;
	logic [5:0]  pick_o;
	logic [IW-1:0] pick_i;
	logic        pick_found;

	function automatic logic [AW:0] obase(input logic [5:0] o);
		logic [AW:0] acc;
		acc = '0;
		for (int k = MIN_ORDER; k <= REGION_ORDER; k++)
			if (k < o) acc = acc + (AW+1)'(1 << (REGION_ORDER - k));
		return acc;
	endfunction

	function automatic logic [IW:0] ocount(input logic [5:0] o);
		return (IW+1)'(1) << (REGION_ORDER - int'(o));
	endfunction

	function automatic logic [5:0] order_for(input logic [31:0] len);
		logic [5:0] k;
		k = 6'd32;
		for (int i = 32; i >= 0; i--)
			if ((64'd1 << i) >= {32'd0, len}) k = 6'(i);
		if (k < 6'(MIN_ORDER)) k = 6'(MIN_ORDER);
		return k;
	endfunction

	logic [31:0] rel;
	logic [5:0]  ord_m1;
	logic [IW-1:0] w_idx, r_idx;
	logic [5:0]  w_ord;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic        wdata, rdata;
	logic        rd_valid_q;

	assign rel = req.address - base;
	assign ord_m1 = ord_q - 6'd1;

	always_comb begin
		w_idx = idx_q;
		w_ord = ord_q;
		unique case (cmd.put_sel)
			SEL_CUR: begin w_idx = idx_q; w_ord = ord_q; end
			SEL_BUDDY: begin w_idx = idx_q ^ IW'(1); w_ord = ord_q; end
			SEL_LEFT: begin w_idx = {idx_q[IW-2:0], 1'b0}; w_ord = ord_m1; end
			SEL_RIGHT: begin w_idx = {idx_q[IW-2:0], 1'b1}; w_ord = ord_m1; end
		endcase
		we = 1'b0;
		waddr = AW'(obase(w_ord) + (AW+1)'(w_idx));
		wdata = cmd.wr_val;
		if (sts.clr_busy) begin
			we = 1'b1;
			waddr = clr_q[AW-1:0];
			wdata = 1'b0;
		end else if (cmd.put) begin
			we = 1'b1;
		end
		r_idx = cmd.rd_buddy ? (idx_q ^ IW'(1)) : idx_q;
		raddr = AW'(obase(ord_q) + (AW+1)'(r_idx));
	end

	bba_ram #(.WIDTH(1), .DEPTH(MAP_BITS)) u_map (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// range block pick: largest aligned block that fits
	always_comb begin
		pick_found = 1'b0;
		pick_o = 6'(MIN_ORDER);
		for (int i = MIN_ORDER; i <= MAX_ORDER; i++)
			if ((33'd1 << i) <= ext_q && ((start_q[31:0] - base) & ((32'd1 << i) - 32'd1)) == 0) begin
				pick_found = 1'b1;
				pick_o = 6'(i);
			end
		pick_i = IW'((start_q[31:0] - base) >> pick_o);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) clr_q <= (AW+1)'(MAP_BITS);
			else if (clr_q != 0) clr_q <= clr_q - 1'b1;
			rd_valid_q <= cmd.scan | cmd.rd_buddy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			want_q <= order_for(req.length);
			ord_q <= order_for(req.length);
			idx_q <= (req.op == OP_ALLOC) ? '0 : IW'(rel >> order_for(req.length));
			blk_addr <= '0;
			if ((rel >> order_for(req.length)) >= 32'(ocount(order_for(req.length))))
				idx_bad_q <= 1'b1;
			else
				idx_bad_q <= 1'b0;
		end
		if (cmd.scan_next) begin
			if (32'(idx_q) + 1 >= 32'(ocount(ord_q))) begin
				idx_q <= '0;
				ord_q <= ord_q + 6'd1;
			end else
				idx_q <= idx_q + IW'(1);
		end
		if (cmd.go_up) begin
			idx_q <= idx_q >> 1;
			ord_q <= ord_q + 6'd1;
		end
		if (cmd.go_down) begin
			idx_q <= {idx_q[IW-2:0], 1'b0};
			ord_q <= ord_m1;
		end
		if (cmd.set_free_blk) begin
			ord_q <= pick_o;
			idx_q <= pick_i;
			idx_bad_q <= ((start_q[31:0] - base) >> pick_o) >= 32'(ocount(pick_o));
			ext_q <= ext_q - (33'd1 << pick_o);
			start_q <= start_q + (33'd1 << pick_o);
		end
		if (cmd.rng_init) begin
			if (req.address[MIN_ORDER-1:0] != 0) begin
				if ({1'b0, req.length} < MIN_SZ[32:0]) ext_q <= '0;
				else ext_q <= {1'b0, req.length}
					- (({1'b0, req.address} & ~33'(MIN_SZ - 1)) + MIN_SZ[32:0]
					- {1'b0, req.address});
				start_q <= ({1'b0, req.address} & ~33'(MIN_SZ - 1)) + MIN_SZ[32:0];
			end else begin
				ext_q <= {1'b0, req.length};
				start_q <= {1'b0, req.address};
			end
		end
		if (cmd.done) blk_addr <= base + (32'(idx_q) << ord_q);
	end

	assign sts.clr_busy = clr_q != 0;
	assign sts.order_big = want_q > 6'(MAX_ORDER);
	assign sts.idx_bad = idx_bad_q;
	assign sts.at_max = ord_q >= 6'(MAX_ORDER);
	assign sts.at_want = ord_q == want_q;
	assign sts.rd_bit = rdata & rd_valid_q;
	assign sts.scan_end = (32'(idx_q) + 1 >= 32'(ocount(ord_q)));
	assign sts.scan_top = ord_q >= 6'(MAX_ORDER);
	assign sts.rng_more = ext_q >= MIN_SZ[32:0]
		&& start_q[MIN_ORDER-1:0] == base[MIN_ORDER-1:0];
	assign sts.rng_ok = pick_found;
endmodule
`default_nettype wire

/* src/bba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic [1:0] op,
	output logic           busy,
	output logic           result_valid,
	output logic [1:0]     status,
	output logic           addr_ok,
	output bba_pkg::cmd_t  cmd,
	input  bba_pkg::sts_t  sts
);
	import bba_pkg::*;
	localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2, S_SCHK = 4'd3,
		S_SPLIT = 4'd4, S_FPUT = 4'd5, S_FCHK = 4'd6, S_FMRG = 4'd7, S_DONE = 4'd8,
		S_RNG = 4'd9, S_RPICK = 4'd10, S_FRD = 4'd11, S_SPL2 = 4'd12, S_CLEAR = 4'd13,
		S_ALLOC = 4'd14, S_FREE = 4'd15;
	logic [3:0] st_q;
	logic [1:0] op_q;
	logic       rng_q;
	logic [1:0] stat_q;
	logic       ok_q;

	always_comb begin
		cmd = '0;
		unique case (st_q)
			S_INIT: cmd.clr_start = 1'b1;
			S_IDLE: begin
				cmd.load = start;
				cmd.rng_init = start && op == OP_RANGE;
			end
			S_SCAN: cmd.scan = 1'b1;
			S_SCHK: begin
				cmd.scan_next = !sts.rd_bit;
				cmd.put = sts.rd_bit;
			end
			S_SPLIT: begin
				cmd.put = 1'b1;
				cmd.put_sel = SEL_RIGHT;
				cmd.wr_val = 1'b1;
				cmd.go_down = 1'b1;
			end
			S_FPUT: begin cmd.put = 1'b1; cmd.wr_val = 1'b1; end
			S_FRD: cmd.rd_buddy = 1'b1;
			S_FCHK: if (sts.rd_bit) begin cmd.put = 1'b1; cmd.put_sel = SEL_BUDDY; end
			S_FMRG: begin cmd.put = 1'b1; cmd.go_up = 1'b1; end
			S_RPICK: cmd.set_free_blk = sts.rng_more && sts.rng_ok;
			S_DONE: cmd.done = op_q == OP_ALLOC && ok_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
			op_q <= OP_ALLOC;
			rng_q <= 1'b0;
			stat_q <= ST_OK;
			ok_q <= 1'b0;
			result_valid <= 1'b0;
			status <= ST_OK;
			addr_ok <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (st_q)
				S_INIT: st_q <= S_CLEAR;
				S_CLEAR: if (!sts.clr_busy) st_q <= S_IDLE;
				S_IDLE: if (start) begin
					op_q <= op; stat_q <= ST_OK; ok_q <= 1'b0; rng_q <= 1'b0;
					unique case (op)
						OP_ALLOC: st_q <= S_ALLOC;
						OP_FREE: st_q <= S_FREE;
						OP_RANGE: begin rng_q <= 1'b1; st_q <= S_RPICK; end
						default: st_q <= S_DONE;
					endcase
				end
				S_ALLOC: if (sts.order_big) begin stat_q <= ST_RANGE; st_q <= S_DONE; end
					else st_q <= S_SCAN;
				S_FREE: if (sts.order_big || sts.idx_bad) begin stat_q <= ST_RANGE;
					st_q <= S_DONE; end else st_q <= S_FPUT;
				S_SCAN: st_q <= S_SCHK;
				S_SCHK: if (sts.rd_bit) begin
					if (sts.at_want) begin ok_q <= 1'b1; st_q <= S_DONE; end
					else st_q <= S_SPLIT;
				end else if (sts.scan_end && sts.scan_top) begin
					stat_q <= ST_EMPTY; st_q <= S_DONE;
				end else st_q <= S_SCAN;
				S_SPLIT: st_q <= S_SPL2;
				S_SPL2: if (sts.at_want) begin ok_q <= 1'b1; st_q <= S_DONE; end
					else st_q <= S_SPLIT;
				S_FPUT: st_q <= sts.at_max ? (rng_q ? S_RPICK : S_DONE) : S_FRD;
				S_FRD: st_q <= S_FCHK;
				S_FCHK: if (sts.rd_bit) st_q <= S_FMRG;
					else st_q <= rng_q ? S_RPICK : S_DONE;
				S_FMRG: st_q <= S_FPUT;
				S_RPICK: if (sts.rng_more && sts.rng_ok) st_q <= S_RNG;
					else st_q <= S_DONE;
				S_RNG: st_q <= sts.idx_bad ? S_RPICK : S_FPUT;
				S_DONE: begin
					result_valid <= 1'b1;
					status <= stat_q;
					addr_ok <= op_q == OP_ALLOC && ok_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
	assign busy = st_q != S_IDLE;
endmodule
`default_nettype wire
